@@ rtl/rrios_pkg.sv @@
package rrios_pkg;

  localparam int NUM_SLOTS   = 3;
  localparam int QUEUE_DEPTH = 8;

  localparam int SLOT_W = 3;
  localparam int SIDX_W = $clog2(NUM_SLOTS);
  localparam int SUM_W  = SLOT_W + 1;
  localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int OFS_W  = PTR_W + 1;
  localparam int TIME_W = 32;
  localparam int WAIT_W = 8;

  localparam logic [WAIT_W-1:0] IO_WAIT_RESET = 8'd3;

  localparam logic REQ_TICK  = 1'b0;
  localparam logic REQ_BLOCK = 1'b1;

  typedef enum logic [1:0] {
    STAT_TICK = 2'd0,
    STAT_ENQ  = 2'd1,
    STAT_FULL = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_REPORT
  } state_t;

  typedef struct packed {
    logic       req_type;
    logic [2:0] proc_id;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [2:0] running_slot;
    logic       switched;
    logic       released_valid;
    logic [2:0] released_slot;
    logic [3:0] blocked_count;
    logic       current_blocked;
  } res_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic report;
  } ctrl_cmd_t;

endpackage

@@ rtl/rrios_ctrl.sv @@
module rrios_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  output rrios_pkg::ctrl_cmd_t cmd
);

  rrios_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rrios_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd.capture = 1'b0;
    cmd.exec    = 1'b0;
    cmd.report  = 1'b0;
    busy        = 1'b1;
    unique case (state_r)
      rrios_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = rrios_pkg::ST_EXEC;
        end
      end
      rrios_pkg::ST_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = rrios_pkg::ST_REPORT;
      end
      rrios_pkg::ST_REPORT: begin
        cmd.report = 1'b1;
        state_nxt  = rrios_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = rrios_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/rrios_dpath.sv @@
module rrios_dpath (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  rrios_pkg::ctrl_cmd_t                 cmd,
  input  rrios_pkg::req_t                      in_data,
  input  logic                                 cfg_we,
  input  logic [rrios_pkg::WAIT_W-1:0]         cfg_wdata,
  output logic                                 out_strobe,
  output rrios_pkg::res_t                      out_data
);

  localparam int ND = rrios_pkg::QUEUE_DEPTH;
  localparam int NS = rrios_pkg::NUM_SLOTS;

  logic [rrios_pkg::WAIT_W-1:0]  io_wait_r;
  rrios_pkg::req_t               item_r;
  logic [rrios_pkg::SLOT_W-1:0]  cur_r, cur_nxt;
  logic [rrios_pkg::PTR_W-1:0]   head_r, head_nxt, tail_r, tail_inc;
  logic [rrios_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [rrios_pkg::TIME_W-1:0]  tick_r, tick_inc;
  logic [rrios_pkg::SLOT_W-1:0]  qslot_r [ND];
  logic [rrios_pkg::TIME_W-1:0]  qtime_r [ND];
  rrios_pkg::res_t               res_r, res_nxt;

  logic [ND-1:0]                 occ;
  logic [NS-1:0]                 blk;
  logic [rrios_pkg::OFS_W-1:0]   ofs;
  logic [rrios_pkg::SUM_W-1:0]   sum;
  logic [rrios_pkg::SLOT_W-1:0]  cand;
  logic                          found;
  logic [rrios_pkg::TIME_W-1:0]  waited;
  logic                          pop;
  logic [rrios_pkg::SLOT_W-1:0]  head_slot;
  logic                          enq;

  // occupancy and per-slot blocked mask
  always_comb begin
    for (int p = 0; p < ND; p++) begin
      if (rrios_pkg::OFS_W'(p) >= rrios_pkg::OFS_W'(head_r)) begin
        ofs = rrios_pkg::OFS_W'(p) - rrios_pkg::OFS_W'(head_r);
      end else begin
        ofs = rrios_pkg::OFS_W'(p) + rrios_pkg::OFS_W'(ND) - rrios_pkg::OFS_W'(head_r);
      end
      occ[p] = (rrios_pkg::CNT_W'(ofs) < cnt_r);
    end
    for (int s = 0; s < NS; s++) begin
      blk[s] = 1'b0;
      for (int p = 0; p < ND; p++) begin
        if (occ[p] && (qslot_r[p] == rrios_pkg::SLOT_W'(s))) begin
          blk[s] = 1'b1;
        end
      end
    end
  end

  // round-robin scan, current slot taken only if no other slot is free
  always_comb begin
    found = 1'b0;
    cand  = cur_r;
    for (int i = NS; i >= 1; i--) begin
      sum = rrios_pkg::SUM_W'(cur_r) + rrios_pkg::SUM_W'(i);
      if (sum >= rrios_pkg::SUM_W'(NS)) begin
        sum = sum - rrios_pkg::SUM_W'(NS);
      end
      if (!blk[sum[rrios_pkg::SIDX_W-1:0]]) begin
        found = 1'b1;
        cand  = sum[rrios_pkg::SLOT_W-1:0];
      end
    end
  end

  always_comb begin
    tick_inc  = tick_r + rrios_pkg::TIME_W'(1);
    waited    = tick_inc - qtime_r[head_r];
    head_slot = qslot_r[head_r];
    pop       = (cnt_r != '0) &&
                (waited >= rrios_pkg::TIME_W'(io_wait_r));
    tail_inc  = (tail_r == rrios_pkg::PTR_W'(ND - 1)) ? '0 : tail_r + rrios_pkg::PTR_W'(1);
    enq       = (item_r.req_type == rrios_pkg::REQ_BLOCK) &&
                (cnt_r < rrios_pkg::CNT_W'(ND));

    cur_nxt  = cur_r;
    head_nxt = head_r;
    cnt_nxt  = cnt_r;
    res_nxt  = res_r;
    res_nxt.released_valid = 1'b0;
    res_nxt.released_slot  = '0;

    if (item_r.req_type == rrios_pkg::REQ_BLOCK) begin
      if (enq) begin
        cnt_nxt        = cnt_r + rrios_pkg::CNT_W'(1);
        res_nxt.status = rrios_pkg::STAT_ENQ;
      end else begin
        res_nxt.status = rrios_pkg::STAT_FULL;
      end
    end else begin
      res_nxt.status = rrios_pkg::STAT_TICK;
      if (found) begin
        cur_nxt = cand;
      end
      if (pop) begin
        res_nxt.released_valid = 1'b1;
        res_nxt.released_slot  = head_slot;
        head_nxt = (head_r == rrios_pkg::PTR_W'(ND - 1)) ? '0 : head_r + rrios_pkg::PTR_W'(1);
        cnt_nxt  = cnt_r - rrios_pkg::CNT_W'(1);
        if (rrios_pkg::SUM_W'(head_slot) < rrios_pkg::SUM_W'(NS)) begin
          cur_nxt = head_slot;
        end
      end
    end
    res_nxt.running_slot  = cur_nxt;
    res_nxt.switched      = (cur_nxt != cur_r);
    res_nxt.blocked_count = 4'(cnt_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      io_wait_r <= rrios_pkg::IO_WAIT_RESET;
      cur_r     <= '0;
      head_r    <= '0;
      tail_r    <= rrios_pkg::PTR_W'(ND - 1);
      cnt_r     <= '0;
      tick_r    <= '0;
    end else begin
      if (cfg_we) begin
        io_wait_r <= cfg_wdata;
      end
      if (cmd.exec) begin
        cur_r  <= cur_nxt;
        head_r <= head_nxt;
        cnt_r  <= cnt_nxt;
        if (item_r.req_type == rrios_pkg::REQ_TICK) begin
          tick_r <= tick_inc;
        end
        if (enq) begin
          tail_r <= tail_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_data;
    end
    if (cmd.exec) begin
      res_r <= res_nxt;
      if (enq) begin
        qslot_r[tail_inc] <= item_r.proc_id;
        qtime_r[tail_inc] <= tick_r;
      end
    end
  end

  always_comb begin
    out_strobe               = cmd.report;
    out_data                 = res_r;
    out_data.current_blocked = blk[cur_r[rrios_pkg::SIDX_W-1:0]];
  end

endmodule

@@ rtl/round_robin_io_block_scheduler_unit.sv @@
// Round-robin slot scheduler with a queue of I/O-blocked slots. Pulse start
// with an item on in_data while busy is low; busy then stays high through the
// controller's execute and report steps, which follow the capture step, and
// the result appears on out_data for the one cycle that out_strobe is high,
// in the report step. The result cannot be held off and must be taken in that
// cycle. Write io_wait_ticks through cfg_we and cfg_wdata only while busy is
// low.
module round_robin_io_block_scheduler_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  rrios_pkg::req_t              in_data,
  output logic                         out_strobe,
  output rrios_pkg::res_t              out_data,
  input  logic                         cfg_we,
  input  logic [rrios_pkg::WAIT_W-1:0] cfg_wdata
);

  rrios_pkg::ctrl_cmd_t cmd;

  rrios_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  rrios_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_data    (in_data),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

endmodule

@@ rtl/rrios_checker.sv @@
module rrios_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         start,
  input logic                         busy,
  input logic                         out_strobe,
  input rrios_pkg::res_t              out_data
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> busy)
    else $error("result shown while idle");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe held for two cycles");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_data.status == rrios_pkg::STAT_TICK ||
                    out_data.status == rrios_pkg::STAT_ENQ ||
                    out_data.status == rrios_pkg::STAT_FULL))
    else $error("bad status code");

  a_block_no_move: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.status != rrios_pkg::STAT_TICK) |->
      (!out_data.switched && !out_data.released_valid))
    else $error("block request moved the running slot or released an item");

endmodule

bind round_robin_io_block_scheduler_unit rrios_checker u_rrios_checker (.*);
